FILE: hw/rtl/smma_pkg.sv
// ----------------------------------------------------------------------------
// smma_pkg
// Types, codes and constants for the scaled matrix multiply-accumulate core.
// ----------------------------------------------------------------------------
package smma_pkg;

    localparam int SMMA_MAX_ROWS_A = 8;
    localparam int SMMA_MAX_COLS_B = 8;
    localparam int SMMA_MAX_SUM_L  = 16;

    // Configuration register indexes
    localparam logic [2:0] CFG_SIZE_A     = 3'd0;
    localparam logic [2:0] CFG_SIZE_B     = 3'd1;
    localparam logic [2:0] CFG_SIZE_L     = 3'd2;
    localparam logic [2:0] CFG_SCALE      = 3'd3;
    localparam logic [2:0] CFG_ACCUMULATE = 3'd4;

    // Register reset values
    localparam logic [3:0]         RST_SIZE_A     = 4'd8;
    localparam logic [3:0]         RST_SIZE_B     = 4'd8;
    localparam logic [4:0]         RST_SIZE_L     = 5'd16;
    localparam logic signed [31:0] RST_SCALE      = 32'sh0001_0000;
    localparam logic               RST_ACCUMULATE = 1'b0;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        KIND_LOAD_S = 2'd0,
        KIND_LOAD_T = 2'd1,
        KIND_LOAD_D = 2'd2,
        KIND_START  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [3:0]         row_index;
        logic [2:0]         col_index;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [31:0] result_value;
        logic               last;
    } t_res;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_FIN
    } t_state;

    // Size register clamped into 1..mx, returned minus one
    function automatic int clamp_m1(int v, int mx);
        int r;
        if (v < 1) begin
            r = 0;
        end else if (v > mx) begin
            r = mx - 1;
        end else begin
            r = v - 1;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/scaled_matrix_multiply_accumulate_core.sv
// ----------------------------------------------------------------------------
// scaled_matrix_multiply_accumulate_core
// D[a][b] = (acc ? D[a][b] : 0) + sum_l factor * S[l][a] * T[l][b], Q16.16.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+---------------------
//  command   | start, busy, i_cmd                         | start & !busy
//  result    | o_res_strobe, o_res                        | strobe, one cycle
//  config    | i_cfg_we, i_cfg_index, i_cfg_wdata         | write enable
//
//  A load transaction leaves the core idle. Every product term of a start
//  transaction passes the one shared 33x33 multiplier three times after a
//  memory read, and each element is then saturated and written back. Each
//  result is registered and appears in the cycle after its write-back.
//  After reset a clearing pass zeroes the D store; busy is high meanwhile.
//  The receiver cannot stall results.
// ----------------------------------------------------------------------------
module scaled_matrix_multiply_accumulate_core
    import smma_pkg::*;
#(
    parameter int MAX_ROWS_A = SMMA_MAX_ROWS_A,
    parameter int MAX_COLS_B = SMMA_MAX_COLS_B,
    parameter int MAX_SUM_L  = SMMA_MAX_SUM_L
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_cmd        i_cmd,
    output logic        o_res_strobe,
    output t_res        o_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata
);

    localparam int S_DEPTH = MAX_SUM_L * MAX_ROWS_A;
    localparam int T_DEPTH = MAX_SUM_L * MAX_COLS_B;
    localparam int D_DEPTH = MAX_ROWS_A * MAX_COLS_B;
    localparam int AW      = (MAX_ROWS_A > 1) ? $clog2(MAX_ROWS_A) : 1;
    localparam int BW      = (MAX_COLS_B > 1) ? $clog2(MAX_COLS_B) : 1;
    localparam int LW      = (MAX_SUM_L > 1) ? $clog2(MAX_SUM_L) : 1;
    localparam int SAW     = (S_DEPTH > 1) ? $clog2(S_DEPTH) : 1;
    localparam int TAW     = (T_DEPTH > 1) ? $clog2(T_DEPTH) : 1;
    localparam int DAW     = (D_DEPTH > 1) ? $clog2(D_DEPTH) : 1;
    // Term below 2^94 in magnitude; headroom for MAX_SUM_L terms and D
    localparam int ACC_W   = 96 + $clog2(MAX_SUM_L + 1) + 2;

    // Configuration registers
    logic [3:0]         r_size_a;
    logic [3:0]         r_size_b;
    logic [4:0]         r_size_l;
    logic signed [31:0] r_scale;
    logic               r_accumulate;

    // Memories
    logic [31:0] s_mem [S_DEPTH];
    logic [31:0] t_mem [T_DEPTH];
    logic [31:0] d_mem [D_DEPTH];

    logic signed [31:0] r_s_rd;
    logic signed [31:0] r_t_rd;
    logic signed [31:0] r_d_rd;

    // Sequencer
    t_state r_state, n_state;
    logic [AW-1:0]  r_a, n_a;
    logic [BW-1:0]  r_b, n_b;
    logic [LW-1:0]  r_l, n_l;
    logic [DAW-1:0] r_clr;

    logic [AW-1:0] na_m1;
    logic [BW-1:0] nb_m1;
    logic [LW-1:0] nl_m1;

    // Datapath
    logic signed [32:0]      mul_a;
    logic signed [32:0]      mul_b;
    logic signed [65:0]      mul_full;
    logic signed [63:0]      r_prod;
    logic signed [31:0]      r_phi;
    logic signed [ACC_W-1:0] r_acc, n_acc;

    logic                     cmd_take;
    logic [SAW-1:0]           s_waddr, s_raddr;
    logic [TAW-1:0]           t_waddr, t_raddr;
    logic [DAW-1:0]           d_laddr, d_addr;
    logic                     s_load_ok, t_load_ok, d_load_ok;
    logic [ACC_W-64:0]        acc_top;
    logic signed [31:0]       sat_val;

    logic               r_res_strobe;
    t_res               r_res;

    assign cmd_take = start && !busy;
    assign busy     = (r_state != ST_IDLE);

    assign na_m1 = AW'(clamp_m1(int'(r_size_a), MAX_ROWS_A));
    assign nb_m1 = BW'(clamp_m1(int'(r_size_b), MAX_COLS_B));
    assign nl_m1 = LW'(clamp_m1(int'(r_size_l), MAX_SUM_L));

    assign s_load_ok = (32'(i_cmd.row_index) < 32'(MAX_SUM_L))
                    && (32'(i_cmd.col_index) < 32'(MAX_ROWS_A));
    assign t_load_ok = (32'(i_cmd.row_index) < 32'(MAX_SUM_L))
                    && (32'(i_cmd.col_index) < 32'(MAX_COLS_B));
    assign d_load_ok = (32'(i_cmd.row_index) < 32'(MAX_ROWS_A))
                    && (32'(i_cmd.col_index) < 32'(MAX_COLS_B));

    assign s_waddr = SAW'(32'(i_cmd.row_index) * 32'(MAX_ROWS_A) + 32'(i_cmd.col_index));
    assign t_waddr = TAW'(32'(i_cmd.row_index) * 32'(MAX_COLS_B) + 32'(i_cmd.col_index));
    assign d_laddr = DAW'(32'(i_cmd.row_index) * 32'(MAX_COLS_B) + 32'(i_cmd.col_index));
    assign s_raddr = SAW'(32'(r_l) * 32'(MAX_ROWS_A) + 32'(r_a));
    assign t_raddr = TAW'(32'(r_l) * 32'(MAX_COLS_B) + 32'(r_b));
    assign d_addr  = DAW'(32'(r_a) * 32'(MAX_COLS_B) + 32'(r_b));

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_a     <= RST_SIZE_A;
            r_size_b     <= RST_SIZE_B;
            r_size_l     <= RST_SIZE_L;
            r_scale      <= RST_SCALE;
            r_accumulate <= RST_ACCUMULATE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SIZE_A:     r_size_a     <= i_cfg_wdata[3:0];
                CFG_SIZE_B:     r_size_b     <= i_cfg_wdata[3:0];
                CFG_SIZE_L:     r_size_l     <= i_cfg_wdata[4:0];
                CFG_SCALE:      r_scale      <= i_cfg_wdata;
                CFG_ACCUMULATE: r_accumulate <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // S and T stores
    always_ff @(posedge i_clk) begin
        if (cmd_take && i_cmd.kind == KIND_LOAD_S && s_load_ok) begin
            s_mem[s_waddr] <= i_cmd.value;
        end
        r_s_rd <= s_mem[s_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cmd_take && i_cmd.kind == KIND_LOAD_T && t_load_ok) begin
            t_mem[t_waddr] <= i_cmd.value;
        end
        r_t_rd <= t_mem[t_raddr];
    end

    // D store: clearing pass, write-back, or host load
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLR) begin
            d_mem[r_clr] <= '0;
        end else if (r_state == ST_FIN) begin
            d_mem[d_addr] <= sat_val;
        end else if (cmd_take && i_cmd.kind == KIND_LOAD_D && d_load_ok) begin
            d_mem[d_laddr] <= i_cmd.value;
        end
        r_d_rd <= d_mem[d_addr];
    end

    // Shared multiplier: S*T, then low and high halves of that times factor
    always_comb begin
        case (r_state)
            ST_M0: begin
                mul_a = 33'(r_s_rd);
                mul_b = 33'(r_t_rd);
            end
            ST_M1: begin
                mul_a = $signed({1'b0, r_prod[31:0]});
                mul_b = 33'(r_scale);
            end
            ST_M2: begin
                mul_a = 33'(r_phi);
                mul_b = 33'(r_scale);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // Shift right by 32 and saturate
    assign acc_top = r_acc[ACC_W-1:63];
    always_comb begin
        if ((&acc_top) || !(|acc_top)) begin
            sat_val = r_acc[63:32];
        end else if (r_acc[ACC_W-1]) begin
            sat_val = SAT_MIN;
        end else begin
            sat_val = SAT_MAX;
        end
    end

    always_comb begin
        n_acc = r_acc;
        case (r_state)
            ST_M0: begin
                if (r_l == '0) begin
                    n_acc = r_accumulate
                          ? $signed({{(ACC_W-64){r_d_rd[31]}}, r_d_rd, 32'b0})
                          : '0;
                end
            end
            ST_M2:   n_acc = r_acc + ACC_W'(r_prod);
            ST_M3:   n_acc = r_acc + $signed({{(ACC_W-96){r_prod[63]}}, r_prod, 32'b0});
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_M0 || r_state == ST_M1 || r_state == ST_M2) begin
            r_prod <= mul_full[63:0];
        end
        if (r_state == ST_M1) begin
            r_phi <= r_prod[63:32];
        end
        r_acc <= n_acc;
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_l     = r_l;
        case (r_state)
            ST_CLR: begin
                if (r_clr == DAW'(D_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cmd_take && i_cmd.kind == KIND_START) begin
                    n_state = ST_RD;
                    n_a     = '0;
                    n_b     = '0;
                    n_l     = '0;
                end
            end
            ST_RD: n_state = ST_M0;
            ST_M0: n_state = ST_M1;
            ST_M1: n_state = ST_M2;
            ST_M2: n_state = ST_M3;
            ST_M3: begin
                if (r_l == nl_m1) begin
                    n_state = ST_FIN;
                end else begin
                    n_l     = r_l + 1'b1;
                    n_state = ST_RD;
                end
            end
            ST_FIN: begin
                n_l = '0;
                if (r_b == nb_m1) begin
                    n_b = '0;
                    if (r_a == na_m1) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_a     = r_a + 1'b1;
                        n_state = ST_RD;
                    end
                end else begin
                    n_b     = r_b + 1'b1;
                    n_state = ST_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr   <= '0;
            r_a     <= '0;
            r_b     <= '0;
            r_l     <= '0;
        end else begin
            r_state <= n_state;
            r_a     <= n_a;
            r_b     <= n_b;
            r_l     <= n_l;
            if (r_state == ST_CLR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    // Result register: one cycle strobe per element
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_strobe <= 1'b0;
        end else begin
            r_res_strobe <= (r_state == ST_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN) begin
            r_res.out_row      <= 3'(r_a);
            r_res.out_col      <= 3'(r_b);
            r_res.result_value <= sat_val;
            r_res.last         <= (r_a == na_m1) && (r_b == nb_m1);
        end
    end

    assign o_res_strobe = r_res_strobe;
    assign o_res        = r_res;

endmodule

FILE: hw/rtl/smma_chk.sv
// ----------------------------------------------------------------------------
// smma_chk
// Port-level checks on the scaled matrix multiply-accumulate core.
// ----------------------------------------------------------------------------
module smma_chk
    import smma_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_cmd i_cmd,
    input logic o_res_strobe,
    input t_res o_res
);

    // A taken start transaction raises busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.kind == KIND_START) |=> busy)
        else $error("start transaction did not raise busy");

    // Load transactions finish in the cycle they are taken
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.kind != KIND_START) |=> !busy)
        else $error("load transaction raised busy");

    // Only the final result of a run coincides with the core going idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> (busy == !o_res.last))
        else $error("last flag disagrees with busy");

    // Results come only out of a running transaction
    a_res_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(busy))
        else $error("result without a running transaction");

    // Strobes of one run are never adjacent
    a_res_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && !o_res.last) |=> !o_res_strobe)
        else $error("back-to-back result strobes");

endmodule

bind scaled_matrix_multiply_accumulate_core smma_chk u_smma_chk (.*);

FILE: tb/smma_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smma_checker
// Watches the command, configuration and result channels of the scaled
// matrix multiply-accumulate core. Keeps its own copy of the S, T and D
// stores and the registers. On every accepted start it computes the result
// elements and queues them. It then compares each strobed result with the
// oldest queued element.
// ----------------------------------------------------------------------------
module smma_checker
    import smma_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_cmd        i_cmd,
    input  logic        i_res_strobe,
    input  t_res        i_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    output int          o_errors,
    output int          o_pending
);

    logic signed [31:0] s_mem [SMMA_MAX_SUM_L][SMMA_MAX_ROWS_A];
    logic signed [31:0] t_mem [SMMA_MAX_SUM_L][SMMA_MAX_COLS_B];
    logic signed [31:0] d_mem [SMMA_MAX_ROWS_A][SMMA_MAX_COLS_B];

    logic [3:0]         reg_size_a;
    logic [3:0]         reg_size_b;
    logic [4:0]         reg_size_l;
    logic signed [31:0] reg_scale;
    logic               reg_acc;

    t_res element_q [$];
    t_res want;

    function automatic int clamp_dim(int v, int mx);
        if (v < 1) begin
            return 1;
        end
        if (v > mx) begin
            return mx;
        end
        return v;
    endfunction

    // Drop 32 fraction bits and saturate to the signed 32-bit range
    function automatic logic signed [31:0] narrow_q16(logic signed [127:0] sum);
        logic [64:0] top_bits;
        top_bits = sum[127:63];
        if (top_bits == '0 || top_bits == '1) begin
            return sum[63:32];
        end
        if (sum[127]) begin
            return SAT_MIN;
        end
        return SAT_MAX;
    endfunction

    task automatic multiply_block();
        int na;
        int nb;
        int nl;
        logic signed [127:0] sum;
        logic signed [127:0] wide_p;
        logic signed [127:0] wide_f;
        logic signed [63:0]  sv;
        logic signed [63:0]  tv;
        logic signed [63:0]  prod;
        logic signed [31:0]  r;
        t_res                e;
        na = clamp_dim(int'(reg_size_a), SMMA_MAX_ROWS_A);
        nb = clamp_dim(int'(reg_size_b), SMMA_MAX_COLS_B);
        nl = clamp_dim(int'(reg_size_l), SMMA_MAX_SUM_L);
        wide_f = reg_scale;
        for (int a = 0; a < na; a++) begin
            for (int b = 0; b < nb; b++) begin
                sum = '0;
                if (reg_acc) begin
                    // stored Q16.16 value lines up with the Q.48 terms
                    sum = d_mem[a][b];
                    sum = sum <<< 32;
                end
                for (int l = 0; l < nl; l++) begin
                    sv     = s_mem[l][a];
                    tv     = t_mem[l][b];
                    prod   = sv * tv;
                    wide_p = prod;
                    sum    = sum + wide_p * wide_f;
                end
                r = narrow_q16(sum);
                d_mem[a][b]    = r;
                e.out_row      = 3'(a);
                e.out_col      = 3'(b);
                e.result_value = r;
                e.last         = (a == na - 1) && (b == nb - 1);
                element_q      = {element_q, e};
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (s_mem[i, j]) s_mem[i][j] = '0;
            foreach (t_mem[i, j]) t_mem[i][j] = '0;
            foreach (d_mem[i, j]) d_mem[i][j] = '0;
            reg_size_a = RST_SIZE_A;
            reg_size_b = RST_SIZE_B;
            reg_size_l = RST_SIZE_L;
            reg_scale  = RST_SCALE;
            reg_acc    = RST_ACCUMULATE;
            element_q.delete();
            o_errors   = 0;
        end else begin
            // retire the result first so the oldest element is compared
            if (i_res_strobe) begin
                if (element_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result, expected none, actual %s",
                             $time,
                             $sformatf("row %0d col %0d value %h last %b",
                                       i_res.out_row, i_res.out_col,
                                       i_res.result_value, i_res.last));
                end else begin
                    want = element_q.pop_front();
                    if (i_res.out_row !== want.out_row || i_res.out_col !== want.out_col ||
                        i_res.result_value !== want.result_value ||
                        i_res.last !== want.last) begin
                        o_errors++;
                        $display("%0t: result mismatch expected row %0d col %0d value %h %s",
                                 $time, want.out_row, want.out_col, want.result_value,
                                 $sformatf("last %b, actual row %0d col %0d value %h last %b",
                                           want.last, i_res.out_row, i_res.out_col,
                                           i_res.result_value, i_res.last));
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SIZE_A:     reg_size_a = i_cfg_wdata[3:0];
                    CFG_SIZE_B:     reg_size_b = i_cfg_wdata[3:0];
                    CFG_SIZE_L:     reg_size_l = i_cfg_wdata[4:0];
                    CFG_SCALE:      reg_scale  = i_cfg_wdata;
                    CFG_ACCUMULATE: reg_acc    = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                case (i_cmd.kind)
                    KIND_LOAD_S: begin
                        if (int'(i_cmd.row_index) < SMMA_MAX_SUM_L &&
                            int'(i_cmd.col_index) < SMMA_MAX_ROWS_A) begin
                            s_mem[i_cmd.row_index][i_cmd.col_index] = i_cmd.value;
                        end
                    end
                    KIND_LOAD_T: begin
                        if (int'(i_cmd.row_index) < SMMA_MAX_SUM_L &&
                            int'(i_cmd.col_index) < SMMA_MAX_COLS_B) begin
                            t_mem[i_cmd.row_index][i_cmd.col_index] = i_cmd.value;
                        end
                    end
                    KIND_LOAD_D: begin
                        if (int'(i_cmd.row_index) < SMMA_MAX_ROWS_A &&
                            int'(i_cmd.col_index) < SMMA_MAX_COLS_B) begin
                            d_mem[i_cmd.row_index][i_cmd.col_index] = i_cmd.value;
                        end
                    end
                    KIND_START: multiply_block();
                    default: ;
                endcase
            end
        end
        o_pending = element_q.size();
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the scaled matrix multiply-accumulate core. Runs a directed
// set of extremes and special cases first. Random phases follow, each with
// its own register setting and sender idling. The checker beside the block
// does all prediction and comparison. This module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import smma_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 160;
    localparam int MAX_GAP      = 30;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_cmd        cmd;
    logic        res_strobe;
    t_res        res;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;

    int errors;
    int pending;
    int eff_a;
    int eff_b;
    int eff_l;
    int idle_pct;
    int quiet_cycles = 0;
    int random_count;
    int phase;
    int n_ops;
    int r;
    int idle_plan [4] = '{0, 55, 0, 11};
    bit s_written [SMMA_MAX_SUM_L][SMMA_MAX_ROWS_A];
    bit t_written [SMMA_MAX_SUM_L][SMMA_MAX_COLS_B];

    scaled_matrix_multiply_accumulate_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (cmd),
        .o_res_strobe(res_strobe),
        .o_res       (res),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    smma_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_cmd       (cmd),
        .i_res_strobe(res_strobe),
        .i_res       (res),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    // End the run when no transaction of any kind has happened for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || res_strobe || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic int clamp_dim(int v, int mx);
        if (v < 1) begin
            return 1;
        end
        if (v > mx) begin
            return mx;
        end
        return v;
    endfunction

    function automatic logic [31:0] pick_q16();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 4))
                    0: return SAT_MIN;
                    1: return SAT_MAX;
                    2: return 32'h0;
                    3: return 32'h0001_0000;
                    default: return 32'hFFFF_0000;
                endcase
            end
            // mostly within +-4.0 so sums stay unsaturated
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic int pick_idx(int lim, int full);
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(0, full - 1);
        end
        return $urandom_range(0, lim - 1);
    endfunction

    function automatic int pick_size(int mx, int over, int hi);
        case ($urandom_range(0, 19))
            0: return 0;
            1: return over;
            2: return mx;
            default: return $urandom_range(1, hi);
        endcase
    endfunction

    task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_SIZE_A: eff_a = clamp_dim(int'(data[3:0]), SMMA_MAX_ROWS_A);
            CFG_SIZE_B: eff_b = clamp_dim(int'(data[3:0]), SMMA_MAX_COLS_B);
            CFG_SIZE_L: eff_l = clamp_dim(int'(data[4:0]), SMMA_MAX_SUM_L);
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic issue(t_kind k, int row, int col, logic [31:0] v);
        t_cmd c;
        int   gap;
        c.kind      = k;
        c.row_index = row[3:0];
        c.col_index = col[2:0];
        c.value     = v;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            gap++;
            @(negedge i_clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
        random_count++;
        if (k == KIND_LOAD_S) begin
            s_written[row][col] = 1'b1;
        end else if (k == KIND_LOAD_T) begin
            t_written[row][col] = 1'b1;
        end
    endtask

    // Load every operand entry the next start will read that was never written
    task automatic launch();
        for (int l = 0; l < eff_l; l++) begin
            for (int a = 0; a < eff_a; a++) begin
                if (!s_written[l][a]) begin
                    issue(KIND_LOAD_S, l, a, pick_q16());
                end
            end
            for (int b = 0; b < eff_b; b++) begin
                if (!t_written[l][b]) begin
                    issue(KIND_LOAD_T, l, b, pick_q16());
                end
            end
        end
        issue(KIND_START, $urandom_range(0, 15), $urandom_range(0, 7), $urandom);
    endtask

    // Hold until all elements are in and the block is idle again
    task automatic settle();
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        while (busy !== 1'b0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic apply_setting(int sa, int sb, int sl, logic [31:0] scale, bit acc);
        settle();
        if ($urandom_range(0, 1) == 1) begin
            cfg_write(3'($urandom_range(5, 7)), $urandom);
        end
        cfg_write(CFG_SIZE_A, ($urandom & 32'hFFFF_FFF0) | 32'(sa));
        cfg_write(CFG_SIZE_B, ($urandom & 32'hFFFF_FFF0) | 32'(sb));
        cfg_write(CFG_SIZE_L, ($urandom & 32'hFFFF_FFE0) | 32'(sl));
        cfg_write(CFG_SCALE, scale);
        cfg_write(CFG_ACCUMULATE, ($urandom & 32'hFFFF_FFFE) | 32'(acc));
    endtask

    initial begin
        i_rst_n   = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        eff_a     = clamp_dim(int'(RST_SIZE_A), SMMA_MAX_ROWS_A);
        eff_b     = clamp_dim(int'(RST_SIZE_B), SMMA_MAX_COLS_B);
        eff_l     = clamp_dim(int'(RST_SIZE_L), SMMA_MAX_SUM_L);
        idle_pct  = 0;
        random_count = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset scale and mode kept: 2.0 * -1.0 overwriting D
        settle();
        cfg_write(CFG_SIZE_A, 32'd1);
        cfg_write(CFG_SIZE_B, 32'd1);
        cfg_write(CFG_SIZE_L, 32'd1);
        issue(KIND_LOAD_S, 0, 0, 32'h0002_0000);
        issue(KIND_LOAD_T, 0, 0, 32'hFFFF_0000);
        launch();

        // Accumulate into a full-scale D, saturating both ways; D row out of range
        apply_setting(1, 1, 1, 32'h0001_0000, 1'b1);
        issue(KIND_LOAD_D, 15, 7, $urandom);
        issue(KIND_LOAD_D, 0, 0, SAT_MAX);
        issue(KIND_LOAD_S, 0, 0, SAT_MAX);
        issue(KIND_LOAD_T, 0, 0, SAT_MAX);
        launch();
        launch();
        issue(KIND_LOAD_S, 0, 0, SAT_MIN);
        launch();

        // Zero and oversized size registers, most negative scale
        apply_setting(0, 15, 0, SAT_MIN, 1'b0);
        issue(KIND_LOAD_S, 15, 7, SAT_MIN);
        issue(KIND_LOAD_T, 15, 7, SAT_MAX);
        issue(KIND_LOAD_T, 0, 7, 32'h0);
        issue(KIND_LOAD_D, 7, 7, SAT_MIN);
        launch();

        // Oversized sum length, most positive scale
        apply_setting(2, 1, 31, SAT_MAX, 1'b1);
        issue(KIND_LOAD_S, 15, 1, 32'hFFFF_0000);
        launch();

        // Zero scale leaves D as it was
        apply_setting(1, 2, 2, 32'h0, 1'b1);
        launch();

        phase = 0;
        while (random_count < RANDOM_ITEMS) begin
            idle_pct = idle_plan[phase % 4];
            if (phase == 3) begin
                // full result grid over a short sum keeps the operand loads few
                apply_setting(SMMA_MAX_ROWS_A, SMMA_MAX_COLS_B, 2,
                              pick_q16(), 1'($urandom));
            end else begin
                apply_setting(pick_size(SMMA_MAX_ROWS_A, 15, 3),
                              pick_size(SMMA_MAX_COLS_B, 15, 3),
                              pick_size(SMMA_MAX_SUM_L, 31, 4),
                              pick_q16(), 1'($urandom));
            end
            n_ops = $urandom_range(3, 12);
            for (int i = 0; i < n_ops; i++) begin
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    issue(KIND_LOAD_S, pick_idx(eff_l, SMMA_MAX_SUM_L),
                          pick_idx(eff_a, SMMA_MAX_ROWS_A), pick_q16());
                end else if (r < 60) begin
                    issue(KIND_LOAD_T, pick_idx(eff_l, SMMA_MAX_SUM_L),
                          pick_idx(eff_b, SMMA_MAX_COLS_B), pick_q16());
                end else if (r < 75) begin
                    issue(KIND_LOAD_D, pick_idx(eff_a, SMMA_MAX_ROWS_A),
                          pick_idx(eff_b, SMMA_MAX_COLS_B), pick_q16());
                end else if (r < 83) begin
                    // D row beyond the store: dropped by the block
                    issue(KIND_LOAD_D, $urandom_range(SMMA_MAX_ROWS_A, 15),
                          $urandom_range(0, 7), $urandom);
                end else begin
                    launch();
                end
            end
            launch();
            phase++;
        end

        settle();
        repeat (12) @(negedge i_clk);
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
